### hdl/trc_pkg.sv
// trc_pkg: shared types, codes and the 5x8 glyph table of the text renderer
// used by trc_ctrl, trc_datapath and text_cursor_glyph_renderer_core
// no dependencies
`default_nettype none

package trc_pkg;

  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  localparam logic [7:0] CHAR_NEWLINE = 8'd10;
  localparam logic [7:0] CHAR_RETURN  = 8'd13;

  localparam int GLYPH_COLS     = 5;
  localparam int GLYPH_ROM_SIZE = 1280;

  typedef enum logic [2:0] {
    REG_TEXT_COLOR,
    REG_BACKGROUND_COLOR,
    REG_TEXT_SIZE,
    REG_START_X,
    REG_START_Y
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WRAP,
    S_BOTTOM,
    S_CLIP,
    S_DRAW,
    S_FLUSH
  } state_t;

  typedef struct packed {
    logic [15:0] text_color;
    logic [15:0] background_color;
    logic [3:0]  text_size;
    logic        load_x;
    logic        load_y;
    logic [15:0] start_value;
  } trc_cfg_t;

  typedef struct packed {
    logic load_code;
    logic newline;
    logic edge_wrap;
    logic bottom;
    logic start_draw;
    logic step;
    logic flush;
  } trc_cmd_t;

  typedef struct packed {
    logic is_newline;
    logic is_return;
    logic visible;
    logic emit;
    logic cell_last;
    logic pend_valid;
    logic out_free;
  } trc_stat_t;

  localparam logic [7:0] GLYPH_ROM [GLYPH_ROM_SIZE] = '{
    8'h00,8'h00,8'h00,8'h00,8'h00, 8'h3E,8'h5B,8'h4F,8'h5B,8'h3E, 8'h3E,8'h6B,8'h4F,8'h6B,8'h3E,
    8'h1C,8'h3E,8'h7C,8'h3E,8'h1C,
    8'h18,8'h3C,8'h7E,8'h3C,8'h18, 8'h1C,8'h57,8'h7D,8'h57,8'h1C, 8'h1C,8'h5E,8'h7F,8'h5E,8'h1C,
    8'h00,8'h18,8'h3C,8'h18,8'h00,
    8'hFF,8'hE7,8'hC3,8'hE7,8'hFF, 8'h00,8'h18,8'h24,8'h18,8'h00, 8'hFF,8'hE7,8'hDB,8'hE7,8'hFF,
    8'h30,8'h48,8'h3A,8'h06,8'h0E,
    8'h26,8'h29,8'h79,8'h29,8'h26, 8'h40,8'h7F,8'h05,8'h05,8'h07, 8'h40,8'h7F,8'h05,8'h25,8'h3F,
    8'h5A,8'h3C,8'hE7,8'h3C,8'h5A,
    8'h7F,8'h3E,8'h1C,8'h1C,8'h08, 8'h08,8'h1C,8'h1C,8'h3E,8'h7F, 8'h14,8'h22,8'h7F,8'h22,8'h14,
    8'h5F,8'h5F,8'h00,8'h5F,8'h5F,
    8'h06,8'h09,8'h7F,8'h01,8'h7F, 8'h00,8'h66,8'h89,8'h95,8'h6A, 8'h60,8'h60,8'h60,8'h60,8'h60,
    8'h94,8'hA2,8'hFF,8'hA2,8'h94,
    8'h08,8'h04,8'h7E,8'h04,8'h08, 8'h10,8'h20,8'h7E,8'h20,8'h10, 8'h08,8'h08,8'h2A,8'h1C,8'h08,
    8'h08,8'h1C,8'h2A,8'h08,8'h08,
    8'h1E,8'h10,8'h10,8'h10,8'h10, 8'h0C,8'h1E,8'h0C,8'h1E,8'h0C, 8'h30,8'h38,8'h3E,8'h38,8'h30,
    8'h06,8'h0E,8'h3E,8'h0E,8'h06,
    8'h00,8'h00,8'h00,8'h00,8'h00, 8'h00,8'h00,8'h5F,8'h00,8'h00, 8'h00,8'h07,8'h00,8'h07,8'h00,
    8'h14,8'h7F,8'h14,8'h7F,8'h14,
    8'h24,8'h2A,8'h7F,8'h2A,8'h12, 8'h23,8'h13,8'h08,8'h64,8'h62, 8'h36,8'h49,8'h56,8'h20,8'h50,
    8'h00,8'h08,8'h07,8'h03,8'h00,
    8'h00,8'h1C,8'h22,8'h41,8'h00, 8'h00,8'h41,8'h22,8'h1C,8'h00, 8'h2A,8'h1C,8'h7F,8'h1C,8'h2A,
    8'h08,8'h08,8'h3E,8'h08,8'h08,
    8'h00,8'h80,8'h70,8'h30,8'h00, 8'h08,8'h08,8'h08,8'h08,8'h08, 8'h00,8'h00,8'h60,8'h60,8'h00,
    8'h20,8'h10,8'h08,8'h04,8'h02,
    8'h3E,8'h51,8'h49,8'h45,8'h3E, 8'h00,8'h42,8'h7F,8'h40,8'h00, 8'h72,8'h49,8'h49,8'h49,8'h46,
    8'h21,8'h41,8'h49,8'h4D,8'h33,
    8'h18,8'h14,8'h12,8'h7F,8'h10, 8'h27,8'h45,8'h45,8'h45,8'h39, 8'h3C,8'h4A,8'h49,8'h49,8'h31,
    8'h41,8'h21,8'h11,8'h09,8'h07,
    8'h36,8'h49,8'h49,8'h49,8'h36, 8'h46,8'h49,8'h49,8'h29,8'h1E, 8'h00,8'h00,8'h14,8'h00,8'h00,
    8'h00,8'h40,8'h34,8'h00,8'h00,
    8'h00,8'h08,8'h14,8'h22,8'h41, 8'h14,8'h14,8'h14,8'h14,8'h14, 8'h00,8'h41,8'h22,8'h14,8'h08,
    8'h02,8'h01,8'h59,8'h09,8'h06,
    8'h3E,8'h41,8'h5D,8'h59,8'h4E, 8'h7C,8'h12,8'h11,8'h12,8'h7C, 8'h7F,8'h49,8'h49,8'h49,8'h36,
    8'h3E,8'h41,8'h41,8'h41,8'h22,
    8'h7F,8'h41,8'h41,8'h41,8'h3E, 8'h7F,8'h49,8'h49,8'h49,8'h41, 8'h7F,8'h09,8'h09,8'h09,8'h01,
    8'h3E,8'h41,8'h41,8'h51,8'h73,
    8'h7F,8'h08,8'h08,8'h08,8'h7F, 8'h00,8'h41,8'h7F,8'h41,8'h00, 8'h20,8'h40,8'h41,8'h3F,8'h01,
    8'h7F,8'h08,8'h14,8'h22,8'h41,
    8'h7F,8'h40,8'h40,8'h40,8'h40, 8'h7F,8'h02,8'h1C,8'h02,8'h7F, 8'h7F,8'h04,8'h08,8'h10,8'h7F,
    8'h3E,8'h41,8'h41,8'h41,8'h3E,
    8'h7F,8'h09,8'h09,8'h09,8'h06, 8'h3E,8'h41,8'h51,8'h21,8'h5E, 8'h7F,8'h09,8'h19,8'h29,8'h46,
    8'h26,8'h49,8'h49,8'h49,8'h32,
    8'h03,8'h01,8'h7F,8'h01,8'h03, 8'h3F,8'h40,8'h40,8'h40,8'h3F, 8'h1F,8'h20,8'h40,8'h20,8'h1F,
    8'h3F,8'h40,8'h38,8'h40,8'h3F,
    8'h63,8'h14,8'h08,8'h14,8'h63, 8'h03,8'h04,8'h78,8'h04,8'h03, 8'h61,8'h59,8'h49,8'h4D,8'h43,
    8'h00,8'h7F,8'h41,8'h41,8'h41,
    8'h02,8'h04,8'h08,8'h10,8'h20, 8'h00,8'h41,8'h41,8'h41,8'h7F, 8'h04,8'h02,8'h01,8'h02,8'h04,
    8'h40,8'h40,8'h40,8'h40,8'h40,
    8'h00,8'h03,8'h07,8'h08,8'h00, 8'h20,8'h54,8'h54,8'h78,8'h40, 8'h7F,8'h28,8'h44,8'h44,8'h38,
    8'h38,8'h44,8'h44,8'h44,8'h28,
    8'h38,8'h44,8'h44,8'h28,8'h7F, 8'h38,8'h54,8'h54,8'h54,8'h18, 8'h00,8'h08,8'h7E,8'h09,8'h02,
    8'h18,8'hA4,8'hA4,8'h9C,8'h78,
    8'h7F,8'h08,8'h04,8'h04,8'h78, 8'h00,8'h44,8'h7D,8'h40,8'h00, 8'h20,8'h40,8'h40,8'h3D,8'h00,
    8'h7F,8'h10,8'h28,8'h44,8'h00,
    8'h00,8'h41,8'h7F,8'h40,8'h00, 8'h7C,8'h04,8'h78,8'h04,8'h78, 8'h7C,8'h08,8'h04,8'h04,8'h78,
    8'h38,8'h44,8'h44,8'h44,8'h38,
    8'hFC,8'h18,8'h24,8'h24,8'h18, 8'h18,8'h24,8'h24,8'h18,8'hFC, 8'h7C,8'h08,8'h04,8'h04,8'h08,
    8'h48,8'h54,8'h54,8'h54,8'h24,
    8'h04,8'h04,8'h3F,8'h44,8'h24, 8'h3C,8'h40,8'h40,8'h20,8'h7C, 8'h1C,8'h20,8'h40,8'h20,8'h1C,
    8'h3C,8'h40,8'h30,8'h40,8'h3C,
    8'h44,8'h28,8'h10,8'h28,8'h44, 8'h4C,8'h90,8'h90,8'h90,8'h7C, 8'h44,8'h64,8'h54,8'h4C,8'h44,
    8'h00,8'h08,8'h36,8'h41,8'h00,
    8'h00,8'h00,8'h77,8'h00,8'h00, 8'h00,8'h41,8'h36,8'h08,8'h00, 8'h02,8'h01,8'h02,8'h04,8'h02,
    8'h3C,8'h26,8'h23,8'h26,8'h3C,
    8'h1E,8'hA1,8'hA1,8'h61,8'h12, 8'h3A,8'h40,8'h40,8'h20,8'h7A, 8'h38,8'h54,8'h54,8'h55,8'h59,
    8'h21,8'h55,8'h55,8'h79,8'h41,
    8'h22,8'h54,8'h54,8'h78,8'h42, 8'h21,8'h55,8'h54,8'h78,8'h40, 8'h20,8'h54,8'h55,8'h79,8'h40,
    8'h0C,8'h1E,8'h52,8'h72,8'h12,
    8'h39,8'h55,8'h55,8'h55,8'h59, 8'h39,8'h54,8'h54,8'h54,8'h59, 8'h39,8'h55,8'h54,8'h54,8'h58,
    8'h00,8'h00,8'h45,8'h7C,8'h41,
    8'h00,8'h02,8'h45,8'h7D,8'h42, 8'h00,8'h01,8'h45,8'h7C,8'h40, 8'h7D,8'h12,8'h11,8'h12,8'h7D,
    8'hF0,8'h28,8'h25,8'h28,8'hF0,
    8'h7C,8'h54,8'h55,8'h45,8'h00, 8'h20,8'h54,8'h54,8'h7C,8'h54, 8'h7C,8'h0A,8'h09,8'h7F,8'h49,
    8'h32,8'h49,8'h49,8'h49,8'h32,
    8'h3A,8'h44,8'h44,8'h44,8'h3A, 8'h32,8'h4A,8'h48,8'h48,8'h30, 8'h3A,8'h41,8'h41,8'h21,8'h7A,
    8'h3A,8'h42,8'h40,8'h20,8'h78,
    8'h00,8'h9D,8'hA0,8'hA0,8'h7D, 8'h3D,8'h42,8'h42,8'h42,8'h3D, 8'h3D,8'h40,8'h40,8'h40,8'h3D,
    8'h3C,8'h24,8'hFF,8'h24,8'h24,
    8'h48,8'h7E,8'h49,8'h43,8'h66, 8'h2B,8'h2F,8'hFC,8'h2F,8'h2B, 8'hFF,8'h09,8'h29,8'hF6,8'h20,
    8'hC0,8'h88,8'h7E,8'h09,8'h03,
    8'h20,8'h54,8'h54,8'h79,8'h41, 8'h00,8'h00,8'h44,8'h7D,8'h41, 8'h30,8'h48,8'h48,8'h4A,8'h32,
    8'h38,8'h40,8'h40,8'h22,8'h7A,
    8'h00,8'h7A,8'h0A,8'h0A,8'h72, 8'h7D,8'h0D,8'h19,8'h31,8'h7D, 8'h26,8'h29,8'h29,8'h2F,8'h28,
    8'h26,8'h29,8'h29,8'h29,8'h26,
    8'h30,8'h48,8'h4D,8'h40,8'h20, 8'h38,8'h08,8'h08,8'h08,8'h08, 8'h08,8'h08,8'h08,8'h08,8'h38,
    8'h2F,8'h10,8'hC8,8'hAC,8'hBA,
    8'h2F,8'h10,8'h28,8'h34,8'hFA, 8'h00,8'h00,8'h7B,8'h00,8'h00, 8'h08,8'h14,8'h2A,8'h14,8'h22,
    8'h22,8'h14,8'h2A,8'h14,8'h08,
    8'h55,8'h00,8'h55,8'h00,8'h55, 8'hAA,8'h55,8'hAA,8'h55,8'hAA, 8'hFF,8'h55,8'hFF,8'h55,8'hFF,
    8'h00,8'h00,8'h00,8'hFF,8'h00,
    8'h10,8'h10,8'h10,8'hFF,8'h00, 8'h14,8'h14,8'h14,8'hFF,8'h00, 8'h10,8'h10,8'hFF,8'h00,8'hFF,
    8'h10,8'h10,8'hF0,8'h10,8'hF0,
    8'h14,8'h14,8'h14,8'hFC,8'h00, 8'h14,8'h14,8'hF7,8'h00,8'hFF, 8'h00,8'h00,8'hFF,8'h00,8'hFF,
    8'h14,8'h14,8'hF4,8'h04,8'hFC,
    8'h14,8'h14,8'h17,8'h10,8'h1F, 8'h10,8'h10,8'h1F,8'h10,8'h1F, 8'h14,8'h14,8'h14,8'h1F,8'h00,
    8'h10,8'h10,8'h10,8'hF0,8'h00,
    8'h00,8'h00,8'h00,8'h1F,8'h10, 8'h10,8'h10,8'h10,8'h1F,8'h10, 8'h10,8'h10,8'h10,8'hF0,8'h10,
    8'h00,8'h00,8'h00,8'hFF,8'h10,
    8'h10,8'h10,8'h10,8'h10,8'h10, 8'h10,8'h10,8'h10,8'hFF,8'h10, 8'h00,8'h00,8'h00,8'hFF,8'h14,
    8'h00,8'h00,8'hFF,8'h00,8'hFF,
    8'h00,8'h00,8'h1F,8'h10,8'h17, 8'h00,8'h00,8'hFC,8'h04,8'hF4, 8'h14,8'h14,8'h17,8'h10,8'h17,
    8'h14,8'h14,8'hF4,8'h04,8'hF4,
    8'h00,8'h00,8'hFF,8'h00,8'hF7, 8'h14,8'h14,8'h14,8'h14,8'h14, 8'h14,8'h14,8'hF7,8'h00,8'hF7,
    8'h14,8'h14,8'h14,8'h17,8'h14,
    8'h10,8'h10,8'h1F,8'h10,8'h1F, 8'h14,8'h14,8'h14,8'hF4,8'h14, 8'h10,8'h10,8'hF0,8'h10,8'hF0,
    8'h00,8'h00,8'h1F,8'h10,8'h1F,
    8'h00,8'h00,8'h00,8'h1F,8'h14, 8'h00,8'h00,8'h00,8'hFC,8'h14, 8'h00,8'h00,8'hF0,8'h10,8'hF0,
    8'h10,8'h10,8'hFF,8'h10,8'hFF,
    8'h14,8'h14,8'h14,8'hFF,8'h14, 8'h10,8'h10,8'h10,8'h1F,8'h00, 8'h00,8'h00,8'h00,8'hF0,8'h10,
    8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,
    8'hF0,8'hF0,8'hF0,8'hF0,8'hF0, 8'hFF,8'hFF,8'hFF,8'h00,8'h00, 8'h00,8'h00,8'h00,8'hFF,8'hFF,
    8'h0F,8'h0F,8'h0F,8'h0F,8'h0F,
    8'h38,8'h44,8'h44,8'h38,8'h44, 8'hFC,8'h4A,8'h4A,8'h4A,8'h34, 8'h7E,8'h02,8'h02,8'h06,8'h06,
    8'h02,8'h7E,8'h02,8'h7E,8'h02,
    8'h63,8'h55,8'h49,8'h41,8'h63, 8'h38,8'h44,8'h44,8'h3C,8'h04, 8'h40,8'h7E,8'h20,8'h1E,8'h20,
    8'h06,8'h02,8'h7E,8'h02,8'h02,
    8'h99,8'hA5,8'hE7,8'hA5,8'h99, 8'h1C,8'h2A,8'h49,8'h2A,8'h1C, 8'h4C,8'h72,8'h01,8'h72,8'h4C,
    8'h30,8'h4A,8'h4D,8'h4D,8'h30,
    8'h30,8'h48,8'h78,8'h48,8'h30, 8'hBC,8'h62,8'h5A,8'h46,8'h3D, 8'h3E,8'h49,8'h49,8'h49,8'h00,
    8'h7E,8'h01,8'h01,8'h01,8'h7E,
    8'h2A,8'h2A,8'h2A,8'h2A,8'h2A, 8'h44,8'h44,8'h5F,8'h44,8'h44, 8'h40,8'h51,8'h4A,8'h44,8'h40,
    8'h40,8'h44,8'h4A,8'h51,8'h40,
    8'h00,8'h00,8'hFF,8'h01,8'h03, 8'hE0,8'h80,8'hFF,8'h00,8'h00, 8'h08,8'h08,8'h6B,8'h6B,8'h08,
    8'h36,8'h12,8'h36,8'h24,8'h36,
    8'h06,8'h0F,8'h09,8'h0F,8'h06, 8'h00,8'h00,8'h18,8'h18,8'h00, 8'h00,8'h00,8'h10,8'h10,8'h00,
    8'h30,8'h40,8'hFF,8'h01,8'h01,
    8'h00,8'h1F,8'h01,8'h01,8'h1E, 8'h00,8'h19,8'h1D,8'h17,8'h12, 8'h00,8'h3C,8'h3C,8'h3C,8'h3C,
    8'h00,8'h00,8'h00,8'h00,8'h00
  };

endpackage

`default_nettype wire

### hdl/trc_ctrl.sv
// trc_ctrl: sequencing state machine of the text renderer
// drives trc_datapath through trc_cmd_t and reads back trc_stat_t; uses trc_pkg
`default_nettype none

module trc_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              char_valid,
  output logic                   char_stall,
  input  wire trc_pkg::trc_stat_t stat,
  output trc_pkg::trc_cmd_t      cmd
);
  import trc_pkg::*;

  state_t state;
  state_t state_next;
  logic   can_step;

  assign can_step = !stat.emit || !stat.pend_valid || stat.out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (char_valid) state_next = S_WRAP;
      end
      S_WRAP: begin
        if (stat.is_newline || stat.is_return) state_next = S_IDLE;
        else state_next = S_BOTTOM;
      end
      S_BOTTOM: begin
        state_next = S_CLIP;
      end
      S_CLIP: begin
        state_next = stat.visible ? S_DRAW : S_IDLE;
      end
      S_DRAW: begin
        if (can_step && stat.cell_last) state_next = S_FLUSH;
      end
      S_FLUSH: begin
        if (!stat.pend_valid || stat.out_free) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd        = '0;
    char_stall = 1'b1;
    case (state)
      S_IDLE: begin
        char_stall    = 1'b0;
        cmd.load_code = char_valid;
      end
      S_WRAP: begin
        cmd.newline   = stat.is_newline;
        cmd.edge_wrap = !stat.is_newline && !stat.is_return;
      end
      S_BOTTOM: begin
        cmd.bottom = 1'b1;
      end
      S_CLIP: begin
        cmd.start_draw = 1'b1;
      end
      S_DRAW: begin
        cmd.step = can_step;
      end
      S_FLUSH: begin
        cmd.flush = stat.pend_valid && stat.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

### hdl/trc_datapath.sv
// trc_datapath: cursor, glyph table read, cell walk and fill request registers
// driven by trc_ctrl; uses trc_pkg for types and the glyph table
`default_nettype none

module trc_datapath #(
  parameter int SCREEN_WIDTH  = 480,
  parameter int SCREEN_HEIGHT = 320,
  parameter int GLYPH_COUNT   = 256
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire trc_pkg::trc_cfg_t cfg,
  input  wire trc_pkg::trc_cmd_t cmd,
  output trc_pkg::trc_stat_t     stat,
  input  wire logic [7:0]        char_code,
  output logic                   rect_valid,
  input  wire logic              rect_stall,
  output logic signed [10:0]     rect_x,
  output logic signed [9:0]      rect_y,
  output logic [3:0]             rect_side,
  output logic [15:0]            fill_color,
  output logic                   last
);
  import trc_pkg::*;

  localparam logic signed [17:0] WIDTH_S  = 18'(SCREEN_WIDTH);
  localparam logic signed [17:0] HEIGHT_S = 18'(SCREEN_HEIGHT);

  logic [7:0]  code;
  logic [15:0] cursor_x;
  logic [15:0] cursor_y;
  logic [15:0] wx;
  logic [15:0] wy;
  logic [15:0] rx;
  logic [15:0] ry;
  logic [2:0]  col_idx;
  logic [2:0]  row_idx;
  logic [2:0]  next_col;
  logic [7:0]  col;
  logic [7:0]  rom_q;
  logic [10:0] rom_addr;
  logic        code_ok;

  logic [6:0]         size6;
  logic [6:0]         size8;
  logic signed [17:0] size6_s;
  logic signed [17:0] size8_s;
  logic signed [17:0] wx_s;
  logic signed [17:0] wy_s;
  logic               edge_hit;
  logic               bottom_hit;
  logic               visible;

  logic        cell_on;
  logic        emit;
  logic [15:0] cell_color;

  logic        pend_valid;
  logic [10:0] pend_x;
  logic [9:0]  pend_y;
  logic [3:0]  pend_side;
  logic [15:0] pend_color;
  logic        out_free;

  assign size6   = 7'({cfg.text_size, 2'b00}) + 7'({cfg.text_size, 1'b0});
  assign size8   = {cfg.text_size, 3'b000};
  assign size6_s = $signed({11'd0, size6});
  assign size8_s = $signed({11'd0, size8});
  assign wx_s    = $signed({{2{wx[15]}}, wx});
  assign wy_s    = $signed({{2{wy[15]}}, wy});

  assign edge_hit   = (wx_s + size6_s) >= WIDTH_S;
  assign bottom_hit = (wy_s - size6_s) <= 18'sd0;
  assign visible    = !((wx_s >= WIDTH_S) || (wy_s >= HEIGHT_S) ||
                        ((wx_s + size6_s - 18'sd1) < 18'sd0) ||
                        ((wy_s + size8_s - 18'sd1) < 18'sd0));

  assign code_ok  = {1'b0, code} < 9'(GLYPH_COUNT);
  assign rom_addr = {1'b0, code, 2'b00} + {3'b000, code} +
                    ((next_col < 3'(GLYPH_COLS)) ? {8'd0, next_col} : 11'd0);

  assign cell_on    = col[row_idx];
  assign emit       = cell_on || (cfg.background_color != cfg.text_color);
  assign cell_color = cell_on ? cfg.text_color : cfg.background_color;
  assign out_free   = !rect_valid || !rect_stall;

  assign stat.is_newline = (code == CHAR_NEWLINE);
  assign stat.is_return  = (code == CHAR_RETURN);
  assign stat.visible    = visible;
  assign stat.emit       = emit;
  assign stat.cell_last  = (col_idx == 3'd5) && (row_idx == 3'd7);
  assign stat.pend_valid = pend_valid;
  assign stat.out_free   = out_free;

  // glyph table read, one column byte per cycle
  always_ff @(posedge clk) begin
    rom_q <= GLYPH_ROM[rom_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_x   <= '0;
      cursor_y   <= '0;
      pend_valid <= 1'b0;
      rect_valid <= 1'b0;
    end else begin
      if (cmd.newline) begin
        cursor_x <= '0;
        cursor_y <= cursor_y - {9'd0, size8};
      end else if (cmd.start_draw) begin
        cursor_x <= wx + {9'd0, size6};
        cursor_y <= wy;
      end else begin
        if (cfg.load_x) cursor_x <= cfg.start_value;
        if (cfg.load_y) cursor_y <= cfg.start_value;
      end
      if (cmd.flush || (cmd.step && emit && pend_valid)) begin
        rect_valid <= 1'b1;
      end else if (rect_valid && !rect_stall) begin
        rect_valid <= 1'b0;
      end
      if (cmd.step && emit) begin
        pend_valid <= 1'b1;
      end else if (cmd.flush) begin
        pend_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_code) begin
      code     <= char_code;
      wx       <= cursor_x;
      wy       <= cursor_y;
      next_col <= '0;
    end
    if (cmd.edge_wrap && edge_hit) begin
      wx <= '0;
      wy <= wy - {9'd0, size8};
    end
    if (cmd.bottom && bottom_hit) begin
      wx <= '0;
      wy <= 16'(SCREEN_HEIGHT - 1);
    end
    if (cmd.start_draw) begin
      rx       <= wx;
      ry       <= wy;
      col_idx  <= '0;
      row_idx  <= '0;
      col      <= code_ok ? rom_q : 8'd0;
      next_col <= 3'd1;
    end
    if (cmd.step) begin
      if (row_idx == 3'd7) begin
        row_idx  <= '0;
        col_idx  <= col_idx + 3'd1;
        rx       <= rx + {12'd0, cfg.text_size};
        ry       <= wy;
        col      <= (code_ok && (next_col < 3'(GLYPH_COLS))) ? rom_q : 8'd0;
        next_col <= next_col + 3'd1;
      end else begin
        row_idx <= row_idx + 3'd1;
        ry      <= ry - {12'd0, cfg.text_size};
      end
    end
  end

  // one cell held back so the final request of a glyph can carry last
  always_ff @(posedge clk) begin
    if (cmd.step && emit) begin
      pend_x     <= rx[10:0];
      pend_y     <= ry[9:0];
      pend_side  <= cfg.text_size;
      pend_color <= cell_color;
      if (pend_valid) begin
        rect_x     <= pend_x;
        rect_y     <= pend_y;
        rect_side  <= pend_side;
        fill_color <= pend_color;
        last       <= 1'b0;
      end
    end
    if (cmd.flush) begin
      rect_x     <= pend_x;
      rect_y     <= pend_y;
      rect_side  <= pend_side;
      fill_color <= pend_color;
      last       <= 1'b1;
    end
  end

  a_flush_has_cell: assert property (@(posedge clk) disable iff (rst)
    cmd.flush |-> (pend_valid && out_free))
    else $error("flush without a held cell or with a blocked output");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (cmd.step && emit && pend_valid) |-> out_free)
    else $error("held cell pushed onto a waiting request");

  a_draw_start: assert property (@(posedge clk) disable iff (rst)
    cmd.start_draw |=> ((col_idx == 3'd0) && (row_idx == 3'd0) && !pend_valid))
    else $error("cell walk not at origin or stale held cell at glyph start");

endmodule

`default_nettype wire

### hdl/text_cursor_glyph_renderer_core.sv
// text_cursor_glyph_renderer_core: top level with the register port
// instantiates trc_ctrl and trc_datapath; uses trc_pkg
`default_nettype none

// Takes one character byte per request and turns it into square fill
// requests for a scaled 5x8 font in a 6x8 cell, one request per drawn cell,
// with last set on the final one. A newline or carriage return returns to
// idle after the wrap state. A drawn character passes cursor wrap, bottom
// and clip checks, a walk over the 6x8 cells at one cell per cycle while the
// output is not stalled, and the release of the held final cell, which waits
// on the output too; a glyph clipped off screen ends after the clip check.
// Registers: text_color (0x00), background_color (0x04), text_size (0x08),
// start_x (0x0c), start_y (0x10). No clearing pass is needed after reset.
module text_cursor_glyph_renderer_core #(
  parameter int SCREEN_WIDTH  = 480,
  parameter int SCREEN_HEIGHT = 320,
  parameter int MAX_TEXT_SIZE = 8,
  parameter int GLYPH_COUNT   = 256
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [trc_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [trc_pkg::DATA_W-1:0]  pwdata,
  output logic [trc_pkg::DATA_W-1:0]       prdata,
  output logic                             pready,
  input  wire logic                        char_valid,
  output logic                             char_stall,
  input  wire logic [7:0]                  char_code,
  output logic                             rect_valid,
  input  wire logic                        rect_stall,
  output logic signed [10:0]               rect_x,
  output logic signed [9:0]                rect_y,
  output logic [3:0]                       rect_side,
  output logic [15:0]                      fill_color,
  output logic                             last
);
  import trc_pkg::*;

  logic [15:0] text_color;
  logic [15:0] background_color;
  logic [3:0]  text_size;
  logic [15:0] start_x;
  logic [15:0] start_y;
  logic [3:0]  size_next;
  logic        reg_write;
  reg_idx_t    reg_idx;
  trc_cfg_t    cfg;
  trc_cmd_t    cmd;
  trc_stat_t   stat;

  assign pready    = 1'b1;
  assign reg_write = psel && penable && pwrite && pready;
  assign reg_idx   = reg_idx_t'(paddr[ADDR_W-1:2]);

  // zero becomes one, oversize saturates
  always_comb begin
    size_next = pwdata[3:0];
    if (pwdata[3:0] == 4'd0) size_next = 4'd1;
    else if ({1'b0, pwdata[3:0]} > 5'(MAX_TEXT_SIZE)) size_next = 4'(MAX_TEXT_SIZE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      text_color       <= 16'hFFFF;
      background_color <= 16'h0000;
      text_size        <= 4'd2;
      start_x          <= '0;
      start_y          <= '0;
    end else if (reg_write) begin
      case (reg_idx)
        REG_TEXT_COLOR:       text_color       <= pwdata[15:0];
        REG_BACKGROUND_COLOR: background_color <= pwdata[15:0];
        REG_TEXT_SIZE:        text_size        <= size_next;
        REG_START_X:          start_x          <= pwdata[15:0];
        REG_START_Y:          start_y          <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_TEXT_COLOR:       prdata = {16'd0, text_color};
      REG_BACKGROUND_COLOR: prdata = {16'd0, background_color};
      REG_TEXT_SIZE:        prdata = {28'd0, text_size};
      REG_START_X:          prdata = {16'd0, start_x};
      REG_START_Y:          prdata = {16'd0, start_y};
      default:              prdata = '0;
    endcase
  end

  assign cfg.text_color       = text_color;
  assign cfg.background_color = background_color;
  assign cfg.text_size        = text_size;
  assign cfg.load_x           = reg_write && (reg_idx == REG_START_X);
  assign cfg.load_y           = reg_write && (reg_idx == REG_START_Y);
  assign cfg.start_value      = pwdata[15:0];

  trc_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .stat       (stat),
    .cmd        (cmd)
  );

  trc_datapath #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT),
    .GLYPH_COUNT   (GLYPH_COUNT)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .cmd        (cmd),
    .stat       (stat),
    .char_code  (char_code),
    .rect_valid (rect_valid),
    .rect_stall (rect_stall),
    .rect_x     (rect_x),
    .rect_y     (rect_y),
    .rect_side  (rect_side),
    .fill_color (fill_color),
    .last       (last)
  );

endmodule

`default_nettype wire
